FILE: hdl/tti_pkg.sv
package tti_pkg;

    localparam int CURVE_LEN   = 33;
    localparam int CURVE_W     = 10;
    localparam int CURVE_IDX_W = 6;
    localparam int TEMP_W      = 15;
    localparam int MDATA_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int BASE_W      = 10;
    localparam int SPAN_W      = 5;
    localparam int FRAC_W      = 7;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int FRAC_SCALE  = 100;
    localparam int TENTHS_DIV  = 10;
    localparam int TEMP_MAX    = 9999;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(500);
    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(10);

    // divide by ten as multiply by ceil(2^20 / 10) and shift; exact below 2^18
    localparam int TENTHS_SHIFT = 20;
    localparam int TENTHS_RECIP = 104858;

    localparam logic [CURVE_W-1:0] CURVE [CURVE_LEN] = '{
        10'd968, 10'd952, 10'd936, 10'd919, 10'd898, 10'd873, 10'd845, 10'd817,
        10'd786, 10'd751, 10'd713, 10'd675, 10'd638, 10'd599, 10'd560, 10'd516,
        10'd477, 10'd436, 10'd403, 10'd371, 10'd338, 10'd310, 10'd283, 10'd257,
        10'd233, 10'd212, 10'd190, 10'd172, 10'd156, 10'd141, 10'd128, 10'd116,
        10'd105
    };

    typedef enum logic [0:0] {
        CFG_BASE_TEMP = 1'b0,
        CFG_SPAN      = 1'b1
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        RS_IN_RANGE = 2'd0,
        RS_COLD     = 2'd1,
        RS_HOT      = 2'd2
    } range_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SEARCH,
        ST_FRAC,
        ST_POS,
        ST_SCALE_LOAD,
        ST_SCALE,
        ST_FINISH,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic classify;
        logic step;
        logic start_frac;
        logic div_step;
        logic make_pos;
        logic start_scale;
        logic div_ten;
        logic finish;
        logic emit;
    } tti_cmd_t;

    typedef struct packed {
        logic cold;
        logic hot;
        logic step_ok;
        logic div_last;
        logic out_busy;
    } tti_status_t;

    function automatic logic [CURVE_W-1:0] curve_at(input logic [CURVE_IDX_W-1:0] k);
        logic [CURVE_IDX_W-1:0] kc;
        kc = (k >= CURVE_IDX_W'(CURVE_LEN)) ? CURVE_IDX_W'(CURVE_LEN - 1) : k;
        return CURVE[kc];
    endfunction

endpackage

FILE: hdl/tti_ctrl.sv
module tti_ctrl
    import tti_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  tti_status_t status,
    output tti_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (status.cold || status.hot) begin
                    cmd.classify = 1'b1;
                    state_next   = ST_EMIT;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (status.step_ok) begin
                    cmd.step = 1'b1;
                end else begin
                    cmd.start_frac = 1'b1;
                    state_next     = ST_FRAC;
                end
            end
            ST_FRAC: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                cmd.make_pos = 1'b1;
                state_next   = ST_SCALE_LOAD;
            end
            ST_SCALE_LOAD: begin
                cmd.start_scale = 1'b1;
                state_next      = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.div_ten = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !status.out_busy)
        else $error("result overwrites a word not yet taken");

    a_load_then_classify: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_CLASSIFY))
        else $error("accepted word not classified next");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd.load)
        else $error("word loaded while busy");
`endif

endmodule

FILE: hdl/tti_datapath.sv
module tti_datapath
    import tti_pkg::*;
#(
    parameter int TABLE_ENTRIES = 33,
    parameter int SAMPLE_BITS   = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [BASE_W-1:0]      base_temp,
    input  logic [SPAN_W-1:0]      span,
    input  tti_cmd_t               cmd,
    output tti_status_t            status,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [TEMP_W-1:0]      m_temp,
    output logic [STATUS_W-1:0]    m_status
);

    localparam int VAL_W = (SAMPLE_BITS > CURVE_W) ? SAMPLE_BITS : CURVE_W;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int POS_W = $clog2((TABLE_ENTRIES - 1) * FRAC_SCALE + 1);
    localparam int NUM_A = VAL_W + FRAC_W;
    localparam int NUM_B = POS_W + SPAN_W;
    localparam int NUM_W = (NUM_A > NUM_B) ? NUM_A : NUM_B;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int PROD_W = NUM_W + TENTHS_SHIFT;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [VAL_W-1:0]    sample_reg, sample_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [VAL_W-1:0]    dvs_reg, dvs_next;
    logic [VAL_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    nq_reg, nq_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                flat_reg, flat_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [TEMP_W-1:0]   res_temp_reg, res_temp_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [TEMP_W-1:0]   m_temp_reg, m_temp_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    logic [IDX_W-1:0]  idx_inc;
    logic [VAL_W-1:0]  hi_v, lo_v, first_v, last_v;
    logic [VAL_W:0]    trial;
    logic              trial_ge;
    logic [FRAC_W-1:0] frac;
    logic [NUM_W:0]    sum;
    logic [PROD_W-1:0] tenths_prod;

    assign idx_inc = idx_reg + IDX_W'(1);
    assign hi_v    = VAL_W'(curve_at(CURVE_IDX_W'(idx_reg)));
    assign lo_v    = VAL_W'(curve_at(CURVE_IDX_W'(idx_inc)));
    assign first_v = VAL_W'(curve_at(CURVE_IDX_W'(0)));
    assign last_v  = VAL_W'(curve_at(CURVE_IDX_W'(LAST_IDX)));

    assign trial       = {rem_reg, nq_reg[NUM_W-1]};
    assign trial_ge    = trial >= {1'b0, dvs_reg};
    assign frac        = flat_reg ? FRAC_W'(FRAC_SCALE) : nq_reg[FRAC_W-1:0];
    assign sum         = (NUM_W + 1)'(base_temp) + (NUM_W + 1)'(nq_reg);
    assign tenths_prod = PROD_W'(nq_reg) * PROD_W'(TENTHS_RECIP);

    assign status.cold     = sample_reg >= first_v;
    assign status.hot      = sample_reg <= last_v;
    assign status.step_ok  = (idx_inc < LAST_IDX) && (sample_reg < lo_v);
    assign status.div_last = cnt_reg == CNT_W'(1);
    assign status.out_busy = m_valid_reg && !m_ready;

    always_comb begin
        sample_next     = sample_reg;
        idx_next        = idx_reg;
        dvs_next        = dvs_reg;
        rem_next        = rem_reg;
        nq_next         = nq_reg;
        cnt_next        = cnt_reg;
        flat_next       = flat_reg;
        pos_next        = pos_reg;
        res_temp_next   = res_temp_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_temp_next     = m_temp_reg;
        m_status_next   = m_status_reg;

        if (cmd.load) begin
            sample_next = VAL_W'(sample);
            idx_next    = '0;
        end
        if (cmd.classify) begin
            if (status.cold) begin
                res_temp_next   = '1;
                res_status_next = RS_COLD;
            end else begin
                res_temp_next   = TEMP_W'(TEMP_MAX);
                res_status_next = RS_HOT;
            end
        end
        if (cmd.step) begin
            idx_next = idx_inc;
        end
        if (cmd.start_frac) begin
            nq_next   = NUM_W'(hi_v - sample_reg) * NUM_W'(FRAC_SCALE);
            dvs_next  = hi_v - lo_v;
            flat_next = hi_v <= lo_v;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
        end
        if (cmd.div_step) begin
            rem_next = trial_ge ? VAL_W'(trial - {1'b0, dvs_reg}) : trial[VAL_W-1:0];
            nq_next  = {nq_reg[NUM_W-2:0], trial_ge};
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.make_pos) begin
            pos_next = POS_W'(idx_reg) * POS_W'(FRAC_SCALE) + POS_W'(frac);
        end
        if (cmd.start_scale) begin
            nq_next = NUM_W'(span) * NUM_W'(pos_reg);
        end
        if (cmd.div_ten) begin
            nq_next = NUM_W'(tenths_prod >> TENTHS_SHIFT);
        end
        if (cmd.finish) begin
            res_temp_next   = (sum > (NUM_W + 1)'(TEMP_MAX)) ? TEMP_W'(TEMP_MAX)
                                                           : TEMP_W'(sum);
            res_status_next = RS_IN_RANGE;
        end
        if (cmd.emit) begin
            m_valid_next  = 1'b1;
            m_temp_next   = res_temp_reg;
            m_status_next = res_status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        idx_reg        <= idx_next;
        dvs_reg        <= dvs_next;
        rem_reg        <= rem_next;
        nq_reg         <= nq_next;
        flat_reg       <= flat_next;
        pos_reg        <= pos_next;
        res_temp_reg   <= res_temp_next;
        res_status_reg <= res_status_next;
        m_temp_reg     <= m_temp_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_temp   = m_temp_reg;
    assign m_status = m_status_reg;

`ifndef SYNTHESIS
    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.make_pos && !flat_reg) |-> (nq_reg <= NUM_W'(FRAC_SCALE)))
        else $error("segment fraction above one hundred");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (cnt_reg != '0))
        else $error("divide step with no bits left");

    a_in_range_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == RS_IN_RANGE))
            |-> (m_temp_reg <= TEMP_W'(TEMP_MAX)))
        else $error("in-range temperature out of bounds");

    a_cold_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == RS_COLD)) |-> (m_temp_reg == '1))
        else $error("cold result not minus one");
`endif

endmodule

FILE: hdl/thermistor_table_interpolator_core.sv
// Channel  Direction  Handshake               Payload
// s_       in         s_tvalid / s_tready     s_tdata: raw_sample
// m_       out        m_tvalid / m_tready     m_tdata: temperature_tenths; m_tuser: range_status
// apb      in         psel / penable          base_temp_tenths @0x0, span_degrees @0x4
//
// One word at a time. A sample at or beyond either table end goes straight from
// classification to a result; an in-range sample first passes the table search, which
// finds the segment index i one entry per cycle, then the restoring divider for the
// segment fraction, whose width is NUM_W (17 by default); the division by ten is one
// reciprocal multiply. The next word can be taken in the same cycle that the result
// appears.
// Reset clears the controller, the result valid flag and both registers to their
// defaults. A stalled result holds in the output register; the next word is taken
// only once the previous result has been moved into it.
module thermistor_table_interpolator_core
    import tti_pkg::*;
#(
    parameter int TABLE_ENTRIES = 33,
    parameter int SAMPLE_BITS   = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // raw_sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [MDATA_W-1:0]                   m_tdata,  // temperature_tenths
    output logic [STATUS_W-1:0]                  m_tuser,  // range_status
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [APB_ADDR_W-1:0]                paddr,
    input  logic [APB_DATA_W-1:0]                pwdata,
    output logic [APB_DATA_W-1:0]                prdata,
    output logic                                 pready
);

    logic [BASE_W-1:0] base_reg, base_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic              cfg_write;
    cfg_index_t        cfg_index;
    tti_cmd_t          cmd;
    tti_status_t       status;
    logic [TEMP_W-1:0] temp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = cfg_index_t'(paddr[2]);

    always_comb begin
        base_next = base_reg;
        span_next = span_reg;
        prdata    = '0;
        unique case (cfg_index)
            CFG_BASE_TEMP: begin
                prdata = APB_DATA_W'(base_reg);
                if (cfg_write) begin
                    base_next = pwdata[BASE_W-1:0];
                end
            end
            CFG_SPAN: begin
                prdata = APB_DATA_W'(span_reg);
                if (cfg_write) begin
                    span_next = pwdata[SPAN_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
            span_reg <= SPAN_RESET;
        end else begin
            base_reg <= base_next;
            span_reg <= span_next;
        end
    end

    tti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tti_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .base_temp (base_reg),
        .span      (span_reg),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_tready),
        .m_valid   (m_tvalid),
        .m_temp    (temp),
        .m_status  (m_tuser)
    );

    assign m_tdata = MDATA_W'(temp);

endmodule
